// File: design/sidec_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds field widths, character codes, BCD constants and the cell control type.
// No dependencies.
`default_nettype none

package sidec_pkg;

  // Field widths.
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;

  // A 32-bit magnitude needs ten decimal digits.
  localparam int NUM_DIGITS = 10;

  // Counter widths.
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int REMAIN_W  = $clog2(NUM_DIGITS + 1);

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Double-dabble correction: a digit of five or more gets three added
  // before it is doubled, so that it carries into the next decade.
  localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

  // Control that the sequencer hands to every digit cell.
  typedef struct packed {
    logic clear;    // load zero into the digit
    logic convert;  // one double-dabble step
    logic shift;    // move digits one place toward the top
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/sidec_stream_if.sv
// Valid/ready stream interfaces for the converter's input and output channels.
// Depends on sidec_pkg for field widths.
`default_nettype none

interface sidec_in_if;
  import sidec_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidec_out_if;
  import sidec_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: design/sidec_bcd_cell.sv
// One decimal digit cell of the double-dabble chain.
// Depends on sidec_pkg for the digit width, BCD constants and control struct.
`default_nettype none

module sidec_bcd_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  sidec_pkg::cell_ctrl_t            ctrl_i,
  input  wire                              sin_i,
  input  wire  [sidec_pkg::DIGIT_W-1:0]    din_i,
  output logic                             sout_o,
  output logic [sidec_pkg::DIGIT_W-1:0]    digit_o
);
  import sidec_pkg::*;

  logic [DIGIT_W-1:0] digit_q;
  logic [DIGIT_W-1:0] digit_d;
  logic [DIGIT_W-1:0] adj;

  // Add three to digits of five or more; the top bit then carries upward.
  assign adj    = (digit_q >= BCD_ADJ_LIMIT) ? (digit_q + BCD_ADJ) : digit_q;
  assign sout_o = adj[DIGIT_W-1];

  // Next digit: clear, shift in one magnitude bit, or take the lower digit.
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.convert) begin
      digit_d = {adj[DIGIT_W-2:0], sin_i};
    end else if (ctrl_i.shift) begin
      digit_d = din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// File: design/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// Steps: the magnitude is shifted bit by bit through the digit cells (double dabble),
// then a minus sign goes out when the value is negative, leading zeros are skipped and
// the digits follow, most significant first.
// A new number is taken only in idle, once the last character of the previous one has
// gone out; a stalled output holds the block.
// Reset: rst_ni is asynchronous and active low; the block returns to idle.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire         clk_i,
  input  wire         rst_ni,
  sidec_in_if.sink    in_i,
  sidec_out_if.source out_o
);
  import sidec_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [VALUE_W-1:0]    mag_q;
  logic [BIT_CNT_W-1:0]  bit_cnt_q;
  logic [REMAIN_W-1:0]   remain_q;
  logic                  sign_pend_q;
  logic                  started_q;

  logic                  in_hs;
  logic                  out_hs;
  logic                  lead_zero;
  logic [VALUE_W-1:0]    raw;
  logic [DIGIT_W-1:0]    top_digit;
  cell_ctrl_t            cell_ctrl;

  logic [DIGIT_W-1:0]    digit [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] sin;
  logic [NUM_DIGITS-2:0] carry;

  // Handshakes.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_hs      = in_i.valid && in_i.ready;
  assign out_hs     = out_o.valid && out_o.ready;
  assign raw        = in_i.value;

  // Leading zeros are skipped, but the last digit always goes out.
  assign top_digit = digit[NUM_DIGITS-1];
  assign lead_zero = !started_q && (top_digit == '0) && (remain_q != REMAIN_W'(1));

  // Output channel, driven from registers.
  assign out_o.valid     = (state_q == ST_EMIT) && (sign_pend_q || !lead_zero);
  assign out_o.character = sign_pend_q ? CHAR_MINUS
                                       : (CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit});
  assign out_o.last      = !sign_pend_q && (remain_q == REMAIN_W'(1));

  // Cell control.
  always_comb begin
    cell_ctrl.clear   = in_hs;
    cell_ctrl.convert = (state_q == ST_CONVERT);
    cell_ctrl.shift   = (state_q == ST_EMIT) && !sign_pend_q && (lead_zero || out_hs);
  end

  // Chain of digit cells, least significant first.
  assign sin[0] = mag_q[VALUE_W-1];
  for (genvar k = 1; k < NUM_DIGITS; k++) begin : g_sin
    assign sin[k] = carry[k-1];
  end

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    if (k == 0) begin : g_low
      sidec_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .sin_i   (sin[k]),
        .din_i   ({DIGIT_W{1'b0}}),
        .sout_o  (carry[k]),
        .digit_o (digit[k])
      );
    end else if (k == NUM_DIGITS - 1) begin : g_top
      sidec_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .sin_i   (sin[k]),
        .din_i   (digit[k-1]),
        .sout_o  (),
        .digit_o (digit[k])
      );
    end else begin : g_mid
      sidec_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .sin_i   (sin[k]),
        .din_i   (digit[k-1]),
        .sout_o  (carry[k]),
        .digit_o (digit[k])
      );
    end
  end

  // Sequencer: take a value, run the conversion, then walk the digits out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      bit_cnt_q   <= '0;
      remain_q    <= '0;
      sign_pend_q <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_hs) begin
            mag_q       <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
            sign_pend_q <= raw[VALUE_W-1];
            bit_cnt_q   <= BIT_CNT_W'(VALUE_W - 1);
            state_q     <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          mag_q     <= {mag_q[VALUE_W-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
          if (bit_cnt_q == '0) begin
            remain_q  <= REMAIN_W'(NUM_DIGITS);
            started_q <= 1'b0;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sign_pend_q) begin
            if (out_hs) begin
              sign_pend_q <= 1'b0;
            end
          end else if (lead_zero) begin
            remain_q <= remain_q - REMAIN_W'(1);
          end else if (out_hs) begin
            started_q <= 1'b1;
            remain_q  <= remain_q - REMAIN_W'(1);
            if (remain_q == REMAIN_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/sidec_checker.sv
// Port-level checks for the signed integer to decimal ASCII converter.
// Depends on sidec_pkg; bound to signed_int_to_decimal_ascii below.
`default_nettype none

module sidec_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_ready_i,
  input wire                             out_valid_i,
  input wire                             out_ready_i,
  input wire [sidec_pkg::CHAR_W-1:0]     out_char_i,
  input wire                             out_last_i
);
  import sidec_pkg::*;

  // A new value is taken only while no text is being offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a character is offered");

  // The conversion runs first, so no character follows an input transaction at once.
  a_convert_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("character offered right after an input transaction");

  // Every character is a minus sign or a decimal digit.
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_char_i == CHAR_MINUS ||
                     (out_char_i >= CHAR_ZERO && out_char_i <= CHAR_ZERO + 8'd9)))
    else $error("character is neither minus nor digit");

  // After the final character the block goes back to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (in_ready_i && !out_valid_i))
    else $error("block not idle after the last character");

  // A stalled character holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_char_i) &&
                                       $stable(out_last_i)))
    else $error("stalled character changed");

endmodule

bind signed_int_to_decimal_ascii sidec_checker u_sidec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.character),
  .out_last_i  (out_o.last)
);

`default_nettype wire
